// ----- hdl/gnmi_pkg.sv -----
// Shared types, codes and index tables for the grid node metric inverse block.
package gnmi_pkg;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_M_LDX,
        S_M_LDY,
        S_M_RUN,
        S_M_STO,
        S_D_LDX,
        S_D_LDY,
        S_D_RUN,
        S_ABS,
        S_ABS2,
        S_V_LDA,
        S_V_ADD,
        S_V_LOAD,
        S_V_CHK,
        S_V_RUN,
        S_V_STO,
        S_PUB
    } state_t;

    // Operations of the shared add/subtract unit
    typedef enum logic [3:0] {
        U_NOP,
        U_LDX,
        U_LDY,
        U_MUL,
        U_LDA,
        U_ADDH,
        U_DLOAD,
        U_DCHK,
        U_DSTEP
    } unit_op_t;

    typedef struct packed {
        unit_op_t op;
        logic     neg;
        logic     clr;
        logic     last;
    } unit_ctl_t;

    localparam int unsigned NUM_SLOTS   = 6;
    localparam int unsigned NUM_AXES    = 3;
    localparam int unsigned NUM_COF     = 9;
    localparam int unsigned NUM_RES     = 10;
    localparam logic [3:0]  LAST_COF    = 4'd8;
    localparam logic [3:0]  LAST_DETCOL = 4'd2;
    localparam logic [3:0]  INV_DET_IDX = 4'd9;
    localparam logic [2:0]  ADDR_THREE_D = 3'd0;

    // Matrix entry index for row/col of a 3x3 (row*3 + col)
    function automatic logic [3:0] mat_idx(input logic [1:0] r, input logic [1:0] c);
        return ({2'b00, r} << 1) + {2'b00, r} + {2'b00, c};
    endfunction

    function automatic logic [1:0] row_of(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] col_of(input logic [3:0] k);
        logic [1:0] c;
        case (k)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            4'd2, 4'd5, 4'd8: c = 2'd2;
            default:          c = 2'd0;
        endcase
        return c;
    endfunction

    // Cofactor sign: odd row+col flips
    function automatic logic cof_odd(input logic [3:0] k);
        logic [1:0] r;
        logic [1:0] c;
        r = row_of(k);
        c = col_of(k);
        return r[0] ^ c[0];
    endfunction

    // Factor of the minor product for cofactor k, product h, operand sel_b
    function automatic logic [3:0] cof_fac(input logic [3:0] k, input logic h,
                                           input logic sel_b);
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] r1;
        logic [1:0] r2;
        logic [1:0] c1;
        logic [1:0] c2;
        logic [1:0] rr;
        logic [1:0] cc;
        r  = row_of(k);
        c  = col_of(k);
        r1 = (r == 2'd0) ? 2'd1 : 2'd0;
        r2 = (r == 2'd2) ? 2'd1 : 2'd2;
        c1 = (c == 2'd0) ? 2'd1 : 2'd0;
        c2 = (c == 2'd2) ? 2'd1 : 2'd2;
        rr = sel_b ? r2 : r1;
        if (!h)
            cc = sel_b ? c2 : c1;
        else
            cc = sel_b ? c1 : c2;
        return mat_idx(rr, cc);
    endfunction

    // Result j = [direction][axis] comes from cofactor [axis][direction]
    function automatic logic [3:0] div_cof(input logic [3:0] j);
        return mat_idx(col_of(j), row_of(j));
    endfunction

endpackage

// ----- hdl/gnmi_store.sv -----
// Neighbor coordinate store and doubled Jacobian entries with planar override.
module gnmi_store #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int MW          = 33
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [2:0]                    wr_slot,
    input  logic signed [COORD_WIDTH-1:0] wr_x,
    input  logic signed [COORD_WIDTH-1:0] wr_y,
    input  logic signed [COORD_WIDTH-1:0] wr_z,
    input  logic                          three_d,
    input  logic [3:0]                    m_idx,
    output logic signed [MW-1:0]          m_rd
);
    import gnmi_pkg::*;

    localparam int NE = NUM_SLOTS * NUM_AXES;

    logic signed [COORD_WIDTH-1:0] coord_reg [NE];
    logic signed [COORD_WIDTH-1:0] wr_data [NUM_AXES];
    logic signed [MW-1:0]          mat [NUM_COF];

    assign wr_data[0] = wr_x;
    assign wr_data[1] = wr_y;
    assign wr_data[2] = wr_z;

    // Store one beat's three coordinates by slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < NE; e++)
                coord_reg[e] <= '0;
        end
        else if (wr_en)
        begin
            for (int e = 0; e < NE; e++)
                if (wr_slot == 3'(e / NUM_AXES))
                    coord_reg[e] <= wr_data[e % NUM_AXES];
        end
    end

    // Doubled Jacobian: right minus left, row = axis, col = direction
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                mat[r*3+c] = MW'(coord_reg[(2*c+1)*3+r]) - MW'(coord_reg[(2*c)*3+r]);
        if (!three_d)
        begin
            mat[2] = '0;
            mat[5] = '0;
            mat[6] = '0;
            mat[7] = '0;
            mat[8] = MW'(1) << (FRAC_BITS + 1);
        end
    end

    assign m_rd = mat[m_idx];

endmodule

// ----- hdl/gnmi_unit.sv -----
// Shared wide add/subtract unit: shift-add multiply and restoring divide steps.
module gnmi_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int MW          = 33,
    parameter int W           = 139
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gnmi_pkg::unit_ctl_t           ctl,
    input  logic signed [W-1:0]           opnd,
    output logic signed [W-1:0]           acc,
    output logic [COORD_WIDTH-1:0]        quo,
    output logic                          ovf
);
    import gnmi_pkg::*;

    logic signed [W-1:0] acc_reg, acc_next;
    logic signed [W-1:0] x_reg, x_next;
    logic [MW-1:0]       y_reg, y_next;
    logic                ovf_reg, ovf_next;
    logic [W-1:0]        add_a, add_b, sum, shl;
    logic                cin, sub, ge;

    // Remainder shifted with the next numerator bit
    assign shl = {acc_reg[W-2:0], y_reg[COORD_WIDTH-1]};
    assign sum = add_a + add_b + W'(cin);
    assign ge  = ~sum[W-1];
    assign sub = ctl.neg ^ ctl.last;

    // Operand selection for the single adder
    always_comb
    begin
        add_a = acc_reg;
        add_b = '0;
        cin   = 1'b0;
        case (ctl.op)
            U_MUL:
            begin
                if (y_reg[0])
                begin
                    add_b = sub ? ~x_reg : x_reg;
                    cin   = sub;
                end
            end
            U_LDA:
            begin
                add_a = '0;
                add_b = ctl.neg ? ~opnd : opnd;
                cin   = ctl.neg;
            end
            U_ADDH:
                add_b = x_reg >>> 1;
            U_DCHK:
            begin
                add_b = ~x_reg;
                cin   = 1'b1;
            end
            U_DSTEP:
            begin
                add_a = shl;
                add_b = ~x_reg;
                cin   = 1'b1;
            end
            default:
                add_b = '0;
        endcase
    end

    // Register updates per operation
    always_comb
    begin
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        ovf_next = ovf_reg;
        case (ctl.op)
            U_LDX:
            begin
                x_next = opnd;
                if (ctl.clr)
                    acc_next = '0;
            end
            U_LDY:
                y_next = opnd[MW-1:0];
            U_MUL:
            begin
                acc_next = sum;
                x_next   = x_reg <<< 1;
                y_next   = MW'($signed(y_reg) >>> 1);
            end
            U_LDA, U_ADDH:
                acc_next = sum;
            U_DLOAD:
            begin
                acc_next = acc_reg >> COORD_WIDTH;
                y_next   = MW'(acc_reg[COORD_WIDTH-1:0]);
            end
            U_DCHK:
                ovf_next = ge;
            U_DSTEP:
            begin
                acc_next = ge ? sum : shl;
                y_next[COORD_WIDTH-1:0] = {y_reg[COORD_WIDTH-2:0], ge};
            end
            default:
                acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovf_reg <= 1'b0;
        else
            ovf_reg <= ovf_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign acc = acc_reg;
    assign quo = y_reg[COORD_WIDTH-1:0];
    assign ovf = ovf_reg;

endmodule

// ----- hdl/grid_node_metric_inverse.sv -----
// Top level: config port, sequencer, cofactor store and result registers.
// A beat without last_of_node only writes the store; a last beat also starts the
// sequence of cofactors, determinant and divides, with multiplies over MW =
// max(COORD_WIDTH+1, FRAC_BITS+3) bits; singular nodes skip the divide setup
// and the 10 divides. Throughput: one node at a time, set by the shared add/sub
// unit doing one multiplier or quotient bit per cycle. Reset: async active low,
// coordinates clear to zero, three_dimensional to 1, no result pending.
module grid_node_metric_inverse #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [15:0]                   node_tag,
    input  logic [2:0]                    neighbor_slot,
    input  logic                          last_of_node,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [15:0]                   result_tag,
    output logic signed [COORD_WIDTH-1:0] xi_dx,
    output logic signed [COORD_WIDTH-1:0] xi_dy,
    output logic signed [COORD_WIDTH-1:0] xi_dz,
    output logic signed [COORD_WIDTH-1:0] eta_dx,
    output logic signed [COORD_WIDTH-1:0] eta_dy,
    output logic signed [COORD_WIDTH-1:0] eta_dz,
    output logic signed [COORD_WIDTH-1:0] zeta_dx,
    output logic signed [COORD_WIDTH-1:0] zeta_dy,
    output logic signed [COORD_WIDTH-1:0] zeta_dz,
    output logic signed [COORD_WIDTH-1:0] inverse_determinant,
    output logic                          singular
);
    import gnmi_pkg::*;

    localparam int MW   = (COORD_WIDTH + 1 > FRAC_BITS + 3) ? COORD_WIDTH + 1 : FRAC_BITS + 3;
    localparam int W    = 3 * MW + 2 * FRAC_BITS + 8;
    localparam int CFW  = 2 * MW + 2;
    localparam int CNTW = $clog2(MW + 1);

    state_t state_reg, state_next;
    logic [3:0]               k_reg;
    logic                     half_reg;
    logic [CNTW-1:0]          cnt_reg;
    logic [15:0]              tag_reg;
    logic                     sing_reg;
    logic                     det_neg_reg;
    logic                     three_d_reg;
    logic signed [CFW-1:0]    cof_reg [NUM_COF];
    logic [COORD_WIDTH-1:0]   res_reg [NUM_RES];
    logic                     out_valid_reg;
    logic [15:0]              out_tag_reg;
    logic                     out_sing_reg;
    logic [COORD_WIDTH-1:0]   out_val_reg [NUM_RES];

    logic                     in_acc, out_acc, cfg_wr;
    logic                     mul_end, div_end, pub_go;
    logic [3:0]               m_idx, cof_idx;
    logic signed [MW-1:0]     m_rd;
    logic signed [CFW-1:0]    cof_rd;
    unit_ctl_t                ctl;
    logic signed [W-1:0]      opnd, acc;
    logic [COORD_WIDTH-1:0]   quo, lim, mag, res_val;
    logic                     ovf, res_neg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid_reg && out_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign mul_end = (cnt_reg == CNTW'(MW - 1));
    assign div_end = (cnt_reg == CNTW'(COORD_WIDTH - 1));
    assign pub_go  = !out_valid_reg || out_ready;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_THREE_D) ? {31'b0, three_d_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            three_d_reg <= 1'b1;
        else if (cfg_wr && paddr == ADDR_THREE_D)
            three_d_reg <= pwdata[0];
    end

    // Coordinate store
    gnmi_store #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .MW          (MW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_acc && neighbor_slot < 3'(NUM_SLOTS)),
        .wr_slot (neighbor_slot),
        .wr_x    (coord_x),
        .wr_y    (coord_y),
        .wr_z    (coord_z),
        .three_d (three_d_reg),
        .m_idx   (m_idx),
        .m_rd    (m_rd)
    );

    // Shared arithmetic unit
    gnmi_unit #(
        .COORD_WIDTH (COORD_WIDTH),
        .MW          (MW),
        .W           (W)
    ) u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .opnd  (opnd),
        .acc   (acc),
        .quo   (quo),
        .ovf   (ovf)
    );

    // Read indices
    always_comb
    begin
        case (state_reg)
            S_M_LDX: m_idx = cof_fac(k_reg, half_reg, 1'b0);
            S_M_LDY: m_idx = cof_fac(k_reg, half_reg, 1'b1);
            default: m_idx = k_reg;
        endcase
        case (state_reg)
            S_M_STO, S_D_LDX: cof_idx = k_reg;
            default:          cof_idx = div_cof(k_reg);
        endcase
    end
    assign cof_rd = cof_reg[cof_idx];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_acc && last_of_node) state_next = S_M_LDX;
            S_M_LDX:  state_next = S_M_LDY;
            S_M_LDY:  state_next = S_M_RUN;
            S_M_RUN:  if (mul_end) state_next = half_reg ? S_M_STO : S_M_LDX;
            S_M_STO:  state_next = (k_reg == LAST_COF) ? S_D_LDX : S_M_LDX;
            S_D_LDX:  state_next = S_D_LDY;
            S_D_LDY:  state_next = S_D_RUN;
            S_D_RUN:  if (mul_end) state_next = (k_reg == LAST_DETCOL) ? S_ABS : S_D_LDX;
            S_ABS:    state_next = (acc == '0) ? S_PUB : S_ABS2;
            S_ABS2:   state_next = S_V_LDA;
            S_V_LDA:  state_next = S_V_ADD;
            S_V_ADD:  state_next = S_V_LOAD;
            S_V_LOAD: state_next = S_V_CHK;
            S_V_CHK:  state_next = S_V_RUN;
            S_V_RUN:  if (div_end) state_next = S_V_STO;
            S_V_STO:  state_next = (k_reg == INV_DET_IDX) ? S_PUB : S_V_LDA;
            S_PUB:    if (pub_go) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Unit control and operand per state
    always_comb
    begin
        ctl  = '{op: U_NOP, neg: 1'b0, clr: 1'b0, last: 1'b0};
        opnd = W'(m_rd);
        case (state_reg)
            S_M_LDX:
            begin
                ctl.op  = U_LDX;
                ctl.clr = !half_reg;
            end
            S_M_LDY: ctl.op = U_LDY;
            S_M_RUN:
            begin
                ctl.op   = U_MUL;
                ctl.neg  = cof_odd(k_reg) ^ half_reg;
                ctl.last = mul_end;
            end
            S_D_LDX:
            begin
                ctl.op  = U_LDX;
                ctl.clr = (k_reg == 4'd0);
                opnd    = W'(cof_rd);
            end
            S_D_LDY: ctl.op = U_LDY;
            S_D_RUN:
            begin
                ctl.op   = U_MUL;
                ctl.last = mul_end;
            end
            S_ABS:
            begin
                ctl.op  = U_LDA;
                ctl.neg = acc[W-1];
                opnd    = acc;
            end
            S_ABS2:
            begin
                ctl.op = U_LDX;
                opnd   = acc <<< 1;
            end
            S_V_LDA:
            begin
                ctl.op = U_LDA;
                if (k_reg == INV_DET_IDX)
                    opnd = W'(1) << (4 * FRAC_BITS + 4);
                else
                begin
                    ctl.neg = cof_rd[CFW-1];
                    opnd    = W'(cof_rd) <<< (2 * FRAC_BITS + 2);
                end
            end
            S_V_ADD:  ctl.op = U_ADDH;
            S_V_LOAD: ctl.op = U_DLOAD;
            S_V_CHK:  ctl.op = U_DCHK;
            S_V_RUN:  ctl.op = U_DSTEP;
            default:  ctl.op = U_NOP;
        endcase
    end

    // Round-half-away quotient to signed saturated result
    always_comb
    begin
        res_neg = det_neg_reg ^ ((k_reg != INV_DET_IDX) && cof_rd[CFW-1]);
        lim     = res_neg ? (COORD_WIDTH'(1) << (COORD_WIDTH - 1))
                          : ((COORD_WIDTH'(1) << (COORD_WIDTH - 1)) - COORD_WIDTH'(1));
        mag     = (ovf || quo > lim) ? lim : quo;
        res_val = res_neg ? (~mag + COORD_WIDTH'(1)) : mag;
    end

    // Sequencer control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            half_reg      <= 1'b0;
            cnt_reg       <= '0;
            sing_reg      <= 1'b0;
            det_neg_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_M_RUN || state_reg == S_D_RUN) && !mul_end)
                cnt_reg <= cnt_reg + CNTW'(1);
            else if (state_reg == S_V_RUN && !div_end)
                cnt_reg <= cnt_reg + CNTW'(1);
            else
                cnt_reg <= '0;
            case (state_reg)
                S_IDLE:
                begin
                    k_reg    <= '0;
                    half_reg <= 1'b0;
                    sing_reg <= 1'b0;
                end
                S_M_RUN:
                    if (mul_end && !half_reg)
                        half_reg <= 1'b1;
                S_M_STO:
                begin
                    half_reg <= 1'b0;
                    k_reg    <= (k_reg == LAST_COF) ? 4'd0 : k_reg + 4'd1;
                end
                S_D_RUN:
                    if (mul_end)
                        k_reg <= (k_reg == LAST_DETCOL) ? 4'd0 : k_reg + 4'd1;
                S_ABS:
                begin
                    det_neg_reg <= acc[W-1];
                    sing_reg    <= (acc == '0);
                end
                S_V_STO:
                    k_reg <= k_reg + 4'd1;
                default:
                    k_reg <= k_reg;
            endcase
            if (state_reg == S_PUB && pub_go)
                out_valid_reg <= 1'b1;
            else if (out_acc)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc && last_of_node)
            tag_reg <= node_tag;
        if (state_reg == S_M_STO)
            cof_reg[k_reg] <= acc[CFW-1:0];
        if (state_reg == S_V_STO)
            res_reg[k_reg] <= res_val;
        if (state_reg == S_PUB && pub_go)
        begin
            out_tag_reg  <= tag_reg;
            out_sing_reg <= sing_reg;
            for (int i = 0; i < NUM_RES; i++)
                out_val_reg[i] <= sing_reg ? '0 : res_reg[i];
        end
    end

    assign in_ready            = (state_reg == S_IDLE);
    assign out_valid           = out_valid_reg;
    assign result_tag          = out_tag_reg;
    assign singular            = out_sing_reg;
    assign xi_dx               = out_val_reg[0];
    assign xi_dy               = out_val_reg[1];
    assign xi_dz               = out_val_reg[2];
    assign eta_dx              = out_val_reg[3];
    assign eta_dy              = out_val_reg[4];
    assign eta_dz              = out_val_reg[5];
    assign zeta_dx             = out_val_reg[6];
    assign zeta_dy             = out_val_reg[7];
    assign zeta_dz             = out_val_reg[8];
    assign inverse_determinant = out_val_reg[9];

`ifndef SYNTH
    // A last beat always starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && last_of_node |=> state_reg == S_M_LDX)
        else $error("last beat did not start computation");

    // A singular result carries zero terms
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> inverse_determinant == '0 && xi_dx == '0 && zeta_dz == '0)
        else $error("singular result with nonzero terms");

    // Step counter stays within the multiplier length
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(MW - 1))
        else $error("step counter overrun");

    // Results publish only from the publish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_PUB)
        else $error("result published outside publish state");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the grid node metric inverse block.
module testbench;
    import gnmi_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [15:0] tag;
        logic [2:0]  slot;
        logic        last;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } beat_t;

    typedef struct {
        logic [15:0] tag;
        logic [31:0] term[9];
        logic [31:0] inv_det;
        logic        sing;
    } metric_t;

    // Scoreboard: keeps a copy of the neighbor store and predicts each node
    class metric_board;
        logic [31:0] coords[18];
        logic        three_d;
        metric_t     pending[$];
        int          errors;

        function new();
            foreach (coords[i]) coords[i] = '0;
            three_d = 1'b1;
            errors  = 0;
        endfunction

        function void set_three_d(logic v);
            three_d = v;
        endfunction

        // round(num/den) half away from zero, saturated to 32 bits
        function logic [31:0] quotient(wide_t num, wide_t den);
            logic [255:0] an;
            logic [255:0] ad;
            logic [255:0] q;
            logic [255:0] lim;
            logic         neg;
            neg = (num < 0) != (den < 0);
            an  = (num < 0) ? -num : num;
            ad  = (den < 0) ? -den : den;
            q   = (2 * an + ad) / (2 * ad);
            lim = neg ? 256'h8000_0000 : 256'h7fff_ffff;
            if (q > lim) q = lim;
            return neg ? -q[31:0] : q[31:0];
        endfunction

        function void note(beat_t b);
            wide_t   m[3][3];
            wide_t   cof[3][3];
            wide_t   det;
            wide_t   hi;
            wide_t   lo;
            metric_t e;
            int      r1, r2, c1, c2;
            if (b.slot <= 5)
            begin
                coords[b.slot*3]   = b.x;
                coords[b.slot*3+1] = b.y;
                coords[b.slot*3+2] = b.z;
            end
            if (!b.last) return;
            // doubled Jacobian
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                begin
                    hi = $signed(coords[(2*c+1)*3+r]);
                    lo = $signed(coords[(2*c)*3+r]);
                    m[r][c] = hi - lo;
                end
            if (!three_d)
            begin
                m[0][2] = 0;
                m[1][2] = 0;
                m[2][0] = 0;
                m[2][1] = 0;
                m[2][2] = wide_t'(1) <<< 17;
            end
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                begin
                    r1 = (r == 0) ? 1 : 0;
                    r2 = (r == 2) ? 1 : 2;
                    c1 = (c == 0) ? 1 : 0;
                    c2 = (c == 2) ? 1 : 2;
                    cof[r][c] = m[r1][c1] * m[r2][c2] - m[r1][c2] * m[r2][c1];
                    if ((r + c) % 2 == 1) cof[r][c] = -cof[r][c];
                end
            det = 0;
            for (int c = 0; c < 3; c++) det = det + m[0][c] * cof[0][c];
            e.tag = b.tag;
            if (det == 0)
            begin
                foreach (e.term[i]) e.term[i] = '0;
                e.inv_det = '0;
                e.sing    = 1'b1;
            end
            else
            begin
                for (int d = 0; d < 3; d++)
                    for (int a = 0; a < 3; a++)
                        e.term[3*d+a] = quotient(cof[a][d] <<< 33, det);
                e.inv_det = quotient(wide_t'(1) <<< 67, det);
                e.sing    = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %h, got %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check(metric_t a);
            metric_t e;
            string   names[9];
            names = '{"xi_dx", "xi_dy", "xi_dz", "eta_dx", "eta_dy", "eta_dz",
                      "zeta_dx", "zeta_dy", "zeta_dz"};
            if (pending.size() == 0)
            begin
                $error("result beat with tag %h but none expected", a.tag);
                errors++;
                return;
            end
            e = pending.pop_front();
            field("result_tag", 32'(e.tag), 32'(a.tag));
            for (int i = 0; i < 9; i++) field(names[i], e.term[i], a.term[i]);
            field("inverse_determinant", e.inv_det, a.inv_det);
            field("singular", 32'(e.sing), 32'(a.sing));
        endfunction
    endclass

    localparam int STALL_LIMIT = 50000;
    localparam int SETTLE      = 1300;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid, in_ready;
    logic [15:0] node_tag;
    logic [2:0]  neighbor_slot;
    logic        last_of_node;
    logic signed [31:0] coord_x, coord_y, coord_z;
    logic out_valid, out_ready;
    logic [15:0] result_tag;
    logic signed [31:0] xi_dx, xi_dy, xi_dz, eta_dx, eta_dy, eta_dz;
    logic signed [31:0] zeta_dx, zeta_dy, zeta_dz, inverse_determinant;
    logic singular;

    metric_board board;
    int snd_idle;
    int rcv_idle;
    int idle_cnt;
    int sent;

    grid_node_metric_inverse DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .node_tag(node_tag), .neighbor_slot(neighbor_slot),
        .last_of_node(last_of_node),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_tag(result_tag),
        .xi_dx(xi_dx), .xi_dy(xi_dy), .xi_dz(xi_dz),
        .eta_dx(eta_dx), .eta_dy(eta_dy), .eta_dz(eta_dz),
        .zeta_dx(zeta_dx), .zeta_dy(zeta_dy), .zeta_dz(zeta_dz),
        .inverse_determinant(inverse_determinant), .singular(singular)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stalls
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= rcv_idle);

    // accept monitor and stall watchdog
    always @(posedge clk)
    begin
        beat_t   b;
        metric_t r;
        if (in_valid && in_ready)
        begin
            b.tag  = node_tag;
            b.slot = neighbor_slot;
            b.last = last_of_node;
            b.x    = coord_x;
            b.y    = coord_y;
            b.z    = coord_z;
            board.note(b);
        end
        if (out_valid && out_ready)
        begin
            r.tag = result_tag;
            r.term = '{xi_dx, xi_dy, xi_dz, eta_dx, eta_dy, eta_dz,
                       zeta_dx, zeta_dy, zeta_dz};
            r.inv_det = inverse_determinant;
            r.sing    = singular;
            board.check(r);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_beat(logic [15:0] tag, logic [2:0] slot, logic last,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z);
        @(negedge clk);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        node_tag      = tag;
        neighbor_slot = slot;
        last_of_node  = last;
        coord_x       = x;
        coord_y       = y;
        coord_z       = z;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    // drop valid, wait for every result, then let the block settle
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_three_d(logic v);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_THREE_D;
        pwdata  = {31'b0, v};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        board.set_three_d(v);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        pwdata  = $urandom;
    endtask

    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h0;
                    default: v = 32'hffff_ffff;
                endcase
            end
            default: v = $signed($urandom) >>> $urandom_range(4, 24);
        endcase
        return v;
    endfunction

    // full neighbor set in random slot order; degenerate copies one pair
    task automatic send_node(logic [15:0] tag, bit degenerate);
        int          order[6];
        int          k, tmp, dir;
        logic [31:0] pts[6][3];
        for (int i = 0; i < 6; i++)
        begin
            order[i] = i;
            for (int a = 0; a < 3; a++) pts[i][a] = rand_coord();
        end
        if (degenerate)
        begin
            dir = $urandom_range(0, 2);
            for (int a = 0; a < 3; a++) pts[2*dir+1][a] = pts[2*dir][a];
        end
        for (int i = 5; i > 0; i--)
        begin
            k = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[k];
            order[k] = tmp;
        end
        for (int i = 0; i < 6; i++)
            send_beat(tag, 3'(order[i]), i == 5, pts[order[i]][0],
                      pts[order[i]][1], pts[order[i]][2]);
    endtask

    task automatic random_phase(int count);
        int stop;
        stop = sent + count;
        while (sent < stop)
        begin
            if ($urandom_range(0, 9) < 8)
                send_node(16'($urandom), $urandom_range(0, 7) == 0);
            else
                send_beat(16'($urandom), 3'($urandom_range(0, 7)),
                          $urandom_range(0, 3) == 0, rand_coord(), rand_coord(),
                          rand_coord());
        end
    endtask

    initial
    begin
        board    = new();
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        node_tag = '0;
        neighbor_slot = '0;
        last_of_node  = 1'b0;
        coord_x  = '0;
        coord_y  = '0;
        coord_z  = '0;
        out_ready = 1'b0;
        snd_idle = 0;
        rcv_idle = 0;
        idle_cnt = 0;
        sent     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: last beat on reset store, unit cube, extremes, singular, bad slots
        send_beat(16'h0000, 3'd0, 1'b1, 32'h0, 32'h0, 32'h0);
        for (int s = 0; s < 6; s++)
            send_beat(16'hffff, 3'(s), s == 5,
                      (s == 0) ? -32'h10000 : (s == 1) ? 32'h10000 : 32'h0,
                      (s == 2) ? -32'h10000 : (s == 3) ? 32'h10000 : 32'h0,
                      (s == 4) ? -32'h10000 : (s == 5) ? 32'h10000 : 32'h0);
        for (int s = 0; s < 6; s++)
            send_beat(16'h1234, 3'(s), s == 5,
                      (s % 2) ? 32'h7fff_ffff : 32'h8000_0000,
                      (s == 3) ? 32'h7fff_ffff : 32'h8000_0000,
                      (s == 5) ? 32'h7fff_ffff : 32'h0);
        send_beat(16'h00ff, 3'd6, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(16'hff00, 3'd7, 1'b1, 32'h5555_5555, 32'haaaa_aaaa, 32'h1);
        send_node(16'habcd, 1'b1);
        send_beat(16'h0f0f, 3'd1, 1'b1, 32'h0, 32'h0, 32'h0);
        drain();

        // random phases across idle patterns and both modes
        for (int p = 0; p < 3; p++)
        begin
            snd_idle = (p == 0) ? 7 : (p == 1) ? 79 : 0;
            rcv_idle = (p == 0) ? 79 : (p == 1) ? 7 : 0;
            write_three_d(1'b0);
            random_phase(250);
            drain();
            write_three_d(1'b1);
            random_phase(250);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
